FILE: design/radix4_trie_insert_search_core_defines.svh
// Assertion macros shared by the trie core checker.
`ifndef RADIX4_TRIE_INSERT_SEARCH_CORE_DEFINES_SVH
`define RADIX4_TRIE_INSERT_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define R4T_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("trie core check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define R4T_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("trie core check failed");

`endif

FILE: design/r4t_pkg.sv
// Types and constants for the radix-4 trie core.
package r4t_pkg;

	localparam int FANOUT     = 4;
	localparam int DIGIT_BITS = 2;
	localparam int KEY_W      = 16;
	localparam int LVL_OUT_W  = 4;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK
	} r4t_state_t;

endpackage

FILE: design/r4t_link_mem.sv
// Child link memory: one write port, one read port with registered data.
module r4t_link_mem #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14,
	parameter int DW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] wa,
	input  logic [DW-1:0] wd,
	input  logic          re,
	input  logic [AW-1:0] ra,
	output logic [DW-1:0] rd
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd <= mem[ra];
		end
	end

endmodule

FILE: design/radix4_trie_insert_search_core.sv
// A walk stops early when a search meets an empty link or an insert finds the node pool used up.
// A new key is taken only once the current walk has ended; one link-memory read per level.
// Each level reads a link, allocates a node on a miss for inserts, then reads the next level.
// Reset: asynchronous; all NODE_POOL*4 links (16384 at default) are swept to zero with
// busy high, then the core goes idle. Results are strobed on done for one cycle.
module radix4_trie_insert_search_core import r4t_pkg::*; #(
	parameter int NODE_POOL = 4096,
	parameter int KEY_BITS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 action,
	input  logic [KEY_W-1:0]     key_value,
	output logic                 busy,
	output logic                 done,
	output logic [LVL_OUT_W-1:0] levels_traversed,
	output logic                 found,
	output logic                 pool_full
);

	localparam int LEVELS = KEY_BITS / 2;
	localparam int NW     = $clog2(NODE_POOL);
	localparam int AW     = NW + DIGIT_BITS;
	localparam int LINKS  = NODE_POOL * FANOUT;
	localparam int LW     = $clog2(LEVELS + 1);
	localparam int KB     = 2 * LEVELS;
	localparam int KX     = (KEY_BITS > KEY_W) ? KEY_BITS : KEY_W;

	r4t_state_t state_q, state_d;

	logic [AW-1:0]        clr_addr_q;
	logic [NW:0]          free_q;
	logic                 done_q;
	logic                 act_q;
	logic [KB-1:0]        key_sh_q;
	logic [LW-1:0]        lvl_q;
	logic [AW-1:0]        idx_q;
	logic [LVL_OUT_W-1:0] lvl_out_q;
	logic                 found_q;
	logic                 full_q;

	logic [KX-1:0]         kx;
	logic [DIGIT_BITS-1:0] dig0;
	logic [DIGIT_BITS-1:0] dig_n;
	logic [KB-1:0]         key_ld;
	logic [NW-1:0]         rd_data;
	logic                  link_zero;
	logic                  pool_out;
	logic                  need_alloc;
	logic                  stop;
	logic                  last;
	logic                  finish;
	logic [NW-1:0]         child;
	logic [LW-1:0]         lvl_inc;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [NW-1:0] wr_data;
	logic          alloc;

	// Level decode on the link that just came back from memory.
	always_comb begin
		kx         = KX'(key_value);
		dig0       = kx[KEY_BITS-1 -: DIGIT_BITS];
		key_ld     = kx[KEY_BITS-1 -: KB];
		dig_n      = key_sh_q[KB-1 -: DIGIT_BITS];
		link_zero  = (rd_data == '0);
		pool_out   = (free_q == (NW+1)'(NODE_POOL));
		need_alloc = !act_q && link_zero;
		stop       = link_zero && (act_q || pool_out);
		child      = link_zero ? free_q[NW-1:0] : rd_data;
		lvl_inc    = LW'(lvl_q + 1'b1);
		last       = (lvl_inc == LW'(LEVELS));
		finish     = stop || last;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == AW'(LINKS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (finish) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy    = 1'b1;
		rd_en   = 1'b0;
		rd_addr = {child, dig_n};
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = free_q[NW-1:0];
		alloc   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_addr_q;
				wr_data = '0;
			end
			ST_IDLE: begin
				busy    = 1'b0;
				rd_en   = start;
				rd_addr = {NW'(0), dig0};
			end
			ST_WALK: begin
				rd_en = !finish;
				alloc = need_alloc && !pool_out;
				wr_en = alloc;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	r4t_link_mem #(
		.DEPTH(LINKS),
		.AW   (AW),
		.DW   (NW)
	) u_mem (
		.clk(clk),
		.we (wr_en),
		.wa (wr_addr),
		.wd (wr_data),
		.re (rd_en),
		.ra (rd_addr),
		.rd (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			free_q     <= (NW+1)'(1);
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_WALK) && finish;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= AW'(clr_addr_q + 1'b1);
			end
			if (alloc) begin
				free_q <= (NW+1)'(free_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			act_q    <= action;
			key_sh_q <= KB'(key_ld << DIGIT_BITS);
			lvl_q    <= '0;
			idx_q    <= rd_addr;
		end
		if (state_q == ST_WALK) begin
			if (finish) begin
				lvl_out_q <= stop ? LVL_OUT_W'(lvl_q) : LVL_OUT_W'(lvl_inc);
				found_q   <= !stop;
				full_q    <= stop && !act_q;
			end else begin
				key_sh_q <= KB'(key_sh_q << DIGIT_BITS);
				lvl_q    <= lvl_inc;
				idx_q    <= rd_addr;
			end
		end
	end

	assign done             = done_q;
	assign levels_traversed = lvl_out_q;
	assign found            = found_q;
	assign pool_full        = full_q;

endmodule

FILE: design/r4t_checker.sv
// Port-level checker for the trie core, bound to the top level.
`include "radix4_trie_insert_search_core_defines.svh"

module r4t_checker #(
	parameter int KEY_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [3:0]  levels_traversed,
	input logic        found,
	input logic        pool_full
);

	localparam logic [3:0] FULL_DEPTH = 4'(KEY_BITS / 2);

	// a key beat taken always starts a walk
	`R4T_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	// one result per key, never two strobes in a row
	`R4T_ASSERT_NEXT(a_done_pulse, done, !done)
	`R4T_ASSERT_NOW(a_found_full_excl, done, !(found && pool_full))
	`R4T_ASSERT_NOW(a_found_depth, done && found, levels_traversed == FULL_DEPTH)

endmodule

bind radix4_trie_insert_search_core r4t_checker #(
	.KEY_BITS(KEY_BITS)
) u_r4t_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.levels_traversed(levels_traversed),
	.found           (found),
	.pool_full       (pool_full)
);

FILE: tb/r4t_tb_pkg.sv
// Command codes shared by the trie core testbench files.
`timescale 1ns / 1ps
package r4t_tb_pkg;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_SEARCH = 1'b1
	} trie_action_t;

endpackage

FILE: tb/radix4_trie_insert_search_core_checker.sv
// Trie core checker: mirrors the link store, predicts each result beat and compares it.
`timescale 1ns / 1ps
module radix4_trie_insert_search_core_checker import r4t_pkg::*, r4t_tb_pkg::*; #(
	parameter int NODE_POOL = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic                 action,
	input  logic [KEY_W-1:0]     key_value,
	input  logic                 done,
	input  logic [LVL_OUT_W-1:0] levels_traversed,
	input  logic                 found,
	input  logic                 pool_full,
	output int                   errors,
	output int                   pending
);

	localparam int LEVELS = KEY_W / DIGIT_BITS;
	localparam int LINKS  = NODE_POOL * FANOUT;

	typedef struct packed {
		logic [LVL_OUT_W-1:0] levels;
		logic                 found;
		logic                 full;
	} trie_outcome_t;

	int unsigned   child_node [LINKS];
	int unsigned   free_node;
	trie_outcome_t outcome_q [$];
	int            err_count = 0;

	// Walks one key through the mirrored trie, allocating on inserts.
	function automatic trie_outcome_t walk_key(input trie_action_t act,
			input logic [KEY_W-1:0] key);
		int unsigned   node;
		int unsigned   walked;
		int unsigned   idx;
		logic [DIGIT_BITS-1:0] digit;
		bit            stop;
		trie_outcome_t res;
		node   = 0;
		walked = 0;
		stop   = 1'b0;
		res    = '0;
		for (int lvl = 0; lvl < LEVELS && !stop; lvl++) begin
			digit = key[KEY_W-1-DIGIT_BITS*lvl -: DIGIT_BITS];
			idx   = node * FANOUT + digit;
			if (child_node[idx] == 0) begin
				if (act == ACT_SEARCH) begin
					stop = 1'b1;
				end else if (free_node >= NODE_POOL) begin
					res.full = 1'b1;
					stop     = 1'b1;
				end else begin
					child_node[idx] = free_node;
					free_node++;
				end
			end
			if (!stop) begin
				node = child_node[idx];
				walked++;
			end
		end
		res.levels = walked[LVL_OUT_W-1:0];
		res.found  = (act == ACT_INSERT) ? !res.full : (walked == LEVELS);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		trie_outcome_t got;
		trie_outcome_t want;
		if (!arst_n) begin
			foreach (child_node[i])
				child_node[i] = 0;
			free_node = 1;
			outcome_q.delete();
			pending <= 0;
		end else begin
			// retire the result beat before taking a new item on the same edge
			if (done) begin
				got = {levels_traversed, found, pool_full};
				if (outcome_q.size() == 0) begin
					$error("result beat with no item outstanding");
					err_count++;
				end else begin
					want = outcome_q.pop_front();
					if (got.levels !== want.levels) begin
						$error("levels_traversed: expected %0d, actual %0d",
							want.levels, got.levels);
						err_count++;
					end
					if (got.found !== want.found) begin
						$error("found: expected %0b, actual %0b", want.found, got.found);
						err_count++;
					end
					if (got.full !== want.full) begin
						$error("pool_full: expected %0b, actual %0b", want.full, got.full);
						err_count++;
					end
				end
			end
			if (start && !busy)
				outcome_q.push_back(walk_key(trie_action_t'(action), key_value));
			pending <= outcome_q.size();
			errors  <= err_count;
		end
	end

endmodule

FILE: tb/radix4_trie_insert_search_core_test.sv
// Trie core testbench top: reset, directed and random key beats, watchdog and verdict.
`timescale 1ns / 1ps
module radix4_trie_insert_search_core_test;
	import r4t_pkg::*;
	import r4t_tb_pkg::*;

	localparam int NODE_POOL   = 4096;
	localparam int ITEMS       = 1150;
	localparam int ITEM_CAP    = 3000;
	localparam int AFTER_FULL  = 150;
	localparam int STALL_LIMIT = 65536;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 action;
	logic [KEY_W-1:0]     key_value;
	logic                 busy;
	logic                 done;
	logic [LVL_OUT_W-1:0] levels_traversed;
	logic                 found;
	logic                 pool_full;
	int                   errors;
	int                   pending;

	int                   quiet_cycles = 0;
	bit                   saw_full = 1'b0;
	logic [KEY_W-1:0]     stored_keys [$];
	logic [KEY_W-1:0]     spread_mask;
	int unsigned          spread_count;

	radix4_trie_insert_search_core #(
		.NODE_POOL(NODE_POOL),
		.KEY_BITS (KEY_W)
	) DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.action          (action),
		.key_value       (key_value),
		.busy            (busy),
		.done            (done),
		.levels_traversed(levels_traversed),
		.found           (found),
		.pool_full       (pool_full)
	);

	radix4_trie_insert_search_core_checker #(
		.NODE_POOL(NODE_POOL)
	) CHECK (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.action          (action),
		.key_value       (key_value),
		.done            (done),
		.levels_traversed(levels_traversed),
		.found           (found),
		.pool_full       (pool_full),
		.errors          (errors),
		.pending         (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// covers the clearing sweep after reset as well as a hung walk
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("radix4_trie_insert_search_core_test: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	always @(posedge clk)
		if (done && pool_full)
			saw_full <= 1'b1;

	task automatic send_beat(input trie_action_t act, input logic [KEY_W-1:0] key);
		start     <= 1'b1;
		action    <= act;
		key_value <= key;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (act == ACT_INSERT)
			stored_keys.push_back(key);
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Low digits of n become the top digits of the key, so consecutive keys
	// split as high in the trie as possible and drain the pool quickly.
	function automatic logic [KEY_W-1:0] spread_key(input int unsigned n);
		logic [KEY_W-1:0] k;
		for (int lvl = 0; lvl < KEY_W / DIGIT_BITS; lvl++)
			k[KEY_W-1-DIGIT_BITS*lvl -: DIGIT_BITS] = n[DIGIT_BITS*lvl +: DIGIT_BITS];
		return k;
	endfunction

	function automatic logic [KEY_W-1:0] pick_stored();
		return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
	endfunction

	task automatic send_random_beat(input bit filling);
		int unsigned r;
		int unsigned t_spread;
		int unsigned t_rand_ins;
		int unsigned t_reins;
		int unsigned t_search;
		int unsigned t_near;
		r          = $urandom_range(0, 99);
		t_spread   = filling ? 70 : 25;
		t_rand_ins = filling ? 76 : 35;
		t_reins    = filling ? 80 : 45;
		t_search   = filling ? 90 : 80;
		t_near     = filling ? 96 : 92;
		if (r < t_spread) begin
			send_beat(ACT_INSERT, spread_key(spread_count) ^ spread_mask);
			spread_count++;
		end else if (r < t_rand_ins) begin
			send_beat(ACT_INSERT, KEY_W'($urandom));
		end else if (r < t_reins) begin
			send_beat(ACT_INSERT, pick_stored());
		end else if (r < t_search) begin
			send_beat(ACT_SEARCH, pick_stored());
		end else if (r < t_near) begin
			// one flipped bit: partial match at a depth set by the bit position
			send_beat(ACT_SEARCH, pick_stored() ^ (16'h1 << $urandom_range(0, KEY_W - 1)));
		end else begin
			send_beat(ACT_SEARCH, KEY_W'($urandom));
		end
	endtask

	initial begin
		int n;
		int full_at;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		action    <= 1'b0;
		key_value <= '0;
		spread_mask  = KEY_W'($urandom);
		spread_count = 0;
		full_at      = -1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(ACT_SEARCH, 16'h1234);
		send_beat(ACT_INSERT, 16'h0000);
		send_beat(ACT_SEARCH, 16'h0000);
		send_beat(ACT_SEARCH, 16'h0001);
		send_beat(ACT_SEARCH, 16'hFFFF);
		send_beat(ACT_INSERT, 16'hFFFF);
		send_beat(ACT_SEARCH, 16'hFFFF);
		send_beat(ACT_INSERT, 16'h0000);
		send_beat(ACT_SEARCH, 16'h8000);
		send_beat(ACT_INSERT, 16'h5555);
		send_beat(ACT_INSERT, 16'hAAAA);
		send_beat(ACT_SEARCH, 16'h4000);
		send_beat(ACT_SEARCH, 16'h5554);
		send_beat(ACT_SEARCH, 16'hAAAB);
		send_beat(ACT_INSERT, 16'h7FFF);
		send_beat(ACT_SEARCH, 16'h7FFE);
		send_beat(ACT_INSERT, 16'h8000);
		send_beat(ACT_SEARCH, 16'h0100);
		send_beat(ACT_SEARCH, 16'hFFFC);
		send_beat(ACT_INSERT, 16'hFFFF);

		n = 0;
		while (n < ITEM_CAP && !(n >= ITEMS && full_at >= 0 && n - full_at >= AFTER_FULL))
		begin
			if (n == 600) begin
				idle_cycles(1);
				while (pending != 0)
					@(posedge clk);
			end
			if (!(n >= 300 && n < 500) && $urandom_range(0, 99) < 28)
				idle_cycles($urandom_range(1, 14));
			send_random_beat(full_at < 0);
			if (saw_full && full_at < 0)
				full_at = n;
			n++;
		end

		idle_cycles(1);
		while (pending != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("radix4_trie_insert_search_core_test: clean");
		else
			$display("radix4_trie_insert_search_core_test: errors");
		$finish;
	end

endmodule

FILE: radix4_trie_insert_search_core.f
+incdir+design
design/r4t_pkg.sv
design/r4t_link_mem.sv
design/radix4_trie_insert_search_core.sv
design/r4t_checker.sv
tb/r4t_tb_pkg.sv
tb/radix4_trie_insert_search_core_checker.sv
tb/radix4_trie_insert_search_core_test.sv
